FILE: design/assert_macros.svh
// Assertion macros used by the translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FRT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FRT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/frt_pkg.sv
// Types, codes and constants of the fragment read translator.
package frt_pkg;

	localparam int DEF_MAX_FRAGMENTS = 64;
	localparam int SECTOR_SHIFT      = 9;
	localparam logic [31:0] CACHE_RESET = 32'hFFFF_FFFF;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic CMD_SEEK = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic        op;
		logic [5:0]  entry_index;
		logic [31:0] frag_start;
		logic [31:0] frag_length;
		logic [31:0] frag_first_sector;
		logic [31:0] read_offset;
		logic [31:0] read_length;
		logic [31:0] read_dest;
	} frt_req_t;

	typedef struct packed {
		logic        command_kind;
		logic [31:0] target_sector;
		logic [6:0]  word_in_sector;
		logic [31:0] transfer_length;
		logic [31:0] transfer_dest;
		logic        last;
	} frt_cmd_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] size;
		logic [31:0] sector;
	} frt_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REL,
		ST_SEC,
		ST_EMIT,
		ST_READ
	} frt_state_t;

endpackage

FILE: design/frt_table.sv
// Fragment table memory: one write port, one registered read port.
module frt_table
	import frt_pkg::*;
#(
	parameter int MAX_FRAGMENTS = DEF_MAX_FRAGMENTS,
	localparam int IDX_W = $clog2(MAX_FRAGMENTS)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  frt_entry_t       wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output frt_entry_t       rdata
);

	frt_entry_t mem [MAX_FRAGMENTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/frt_scan.sv
// Scan sequencer: table walk, sector math, seek cache and command register.
`include "assert_macros.svh"
module frt_scan
	import frt_pkg::*;
#(
	parameter int MAX_FRAGMENTS = DEF_MAX_FRAGMENTS,
	localparam int IDX_W = $clog2(MAX_FRAGMENTS),
	localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             second_disc,
	input  logic             req_valid,
	output logic             req_stall,
	input  frt_req_t         req,
	output logic             cmd_valid,
	input  logic             cmd_stall,
	output frt_cmd_t         cmd,
	output logic             tbl_we,
	output logic [IDX_W-1:0] tbl_waddr,
	output frt_entry_t       tbl_wdata,
	output logic             tbl_re,
	output logic [IDX_W-1:0] tbl_raddr,
	input  frt_entry_t       tbl_rdata
);

	localparam logic [CNT_W-1:0] LIMIT_FULL = CNT_W'(MAX_FRAGMENTS);
	localparam logic [CNT_W-1:0] LIMIT_HALF = CNT_W'(MAX_FRAGMENTS / 2);

	frt_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, limit;
	logic pend_s1, pend_d;
	logic [31:0] offset_q, len_q, dest_q;
	logic [31:0] start_q, sector_q, rel_q, sec_q, cached_q;
	logic [31:0] idx_ext, entry_end;
	logic req_acc, match, out_free, out_valid_q;
	logic latch_req, latch_entry, emit_seek, emit_read;
	frt_cmd_t out_q;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign limit     = second_disc ? LIMIT_HALF : LIMIT_FULL;
	assign out_free  = !out_valid_q || !cmd_stall;
	assign cmd_valid = out_valid_q;
	assign cmd       = out_q;

	// Load beats go straight to the table; out-of-range slots are dropped.
	assign idx_ext   = 32'(req.entry_index);
	assign tbl_we    = req_acc && (req.op == OP_LOAD) && (idx_ext < 32'(MAX_FRAGMENTS));
	assign tbl_waddr = idx_ext[IDX_W-1:0];
	assign tbl_wdata = '{start: req.frag_start, size: req.frag_length,
		sector: req.frag_first_sector};
	assign tbl_raddr = cnt_q[IDX_W-1:0];

	assign entry_end = tbl_rdata.start + tbl_rdata.size;
	assign match     = pend_s1 && (offset_q >= tbl_rdata.start) && (offset_q <= entry_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		pend_d      = 1'b0;
		tbl_re      = 1'b0;
		latch_req   = 1'b0;
		latch_entry = 1'b0;
		emit_seek   = 1'b0;
		emit_read   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc && (req.op == OP_READ)) begin
					latch_req = 1'b1;
					cnt_d     = '0;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// First hit wins; no further entries are read after it.
				priority if (match) begin
					latch_entry = 1'b1;
					state_d     = ST_REL;
				end else if (cnt_q < limit) begin
					tbl_re = 1'b1;
					pend_d = 1'b1;
					cnt_d  = cnt_q + CNT_W'(1);
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REL: state_d = ST_SEC;
			ST_SEC: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					if (sec_q != cached_q) begin
						emit_seek = 1'b1;
						state_d   = ST_READ;
					end else begin
						emit_read = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_READ: begin
				if (out_free) begin
					emit_read = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (latch_req) begin
			offset_q <= req.read_offset;
			len_q    <= req.read_length;
			dest_q   <= req.read_dest;
		end
		if (latch_entry) begin
			start_q  <= tbl_rdata.start;
			sector_q <= tbl_rdata.sector;
		end
		if (state_q == ST_REL) begin
			rel_q <= offset_q - start_q;
		end
		if (state_q == ST_SEC) begin
			sec_q <= sector_q + (rel_q >> SECTOR_SHIFT);
		end
		if (emit_seek) begin
			out_q <= '{command_kind: CMD_SEEK, target_sector: sec_q, word_in_sector: '0,
				transfer_length: '0, transfer_dest: '0, last: 1'b0};
		end else if (emit_read) begin
			out_q <= '{command_kind: CMD_READ, target_sector: sec_q,
				word_in_sector: rel_q[8:2], transfer_length: len_q,
				transfer_dest: dest_q, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cached_q    <= CACHE_RESET;
		end else begin
			if (emit_seek || emit_read) begin
				out_valid_q <= 1'b1;
			end else if (!cmd_stall) begin
				out_valid_q <= 1'b0;
			end
			if (emit_seek) begin
				cached_q <= sec_q;
			end
		end
	end

	`FRT_ASSERT_IMPL(a_seek_then_read, clk, arst_n,
		out_valid_q && (out_q.command_kind == CMD_SEEK), state_q == ST_READ)
	`FRT_ASSERT_IMPL(a_seek_sets_cache, clk, arst_n,
		out_valid_q && (out_q.command_kind == CMD_SEEK), cached_q == out_q.target_sector)
	`FRT_ASSERT_IMPL(a_cnt_in_range, clk, arst_n, state_q == ST_SCAN, cnt_q <= limit)
	`FRT_ASSERT_NEXT(a_read_is_last, clk, arst_n, emit_read,
		out_q.last && (out_q.command_kind == CMD_READ))
	`FRT_ASSERT_IMPL(a_pend_only_scan, clk, arst_n, pend_s1, state_q == ST_SCAN)

endmodule

FILE: design/fragment_read_translator_core.sv
// Top level of the fragment read translator: config register, table and scan sequencer.
//
//  channel | role     | handshake              | payload
//  req     | input    | req_valid / req_stall  | frt_req_t (load entry or read request)
//  cmd     | output   | cmd_valid / cmd_stall  | frt_cmd_t (seek or read command)
//  cfg     | config   | cfg_valid / cfg_ready  | cfg_data (second_disc_present)
//
// A load beat writes the table memory directly. A read beat walks the table
// one entry per cycle through its single read port: a scan of up to N entries
// (N = MAX_FRAGMENTS, or half of it with a second disc), sector math and one or
// two command beats; no new beat is taken until the sequencer is back in idle.
// arst_n clears the sequencer, the command valid flag and the seek cache (all
// ones); table contents are undefined until loaded. cmd_stall holds the command
// register; a command that cannot be sent holds the sequencer and the input.
module fragment_read_translator_core
	import frt_pkg::*;
#(
	parameter int MAX_FRAGMENTS = DEF_MAX_FRAGMENTS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  frt_req_t req,
	output logic     cmd_valid,
	input  logic     cmd_stall,
	output frt_cmd_t cmd,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);

	localparam int IDX_W = $clog2(MAX_FRAGMENTS);

	logic second_disc_q;
	logic tbl_we, tbl_re;
	logic [IDX_W-1:0] tbl_waddr, tbl_raddr;
	frt_entry_t tbl_wdata, tbl_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_disc_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			second_disc_q <= cfg_data;
		end
	end

	frt_table #(.MAX_FRAGMENTS(MAX_FRAGMENTS)) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	frt_scan #(.MAX_FRAGMENTS(MAX_FRAGMENTS)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.second_disc (second_disc_q),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.tbl_we      (tbl_we),
		.tbl_waddr   (tbl_waddr),
		.tbl_wdata   (tbl_wdata),
		.tbl_re      (tbl_re),
		.tbl_raddr   (tbl_raddr),
		.tbl_rdata   (tbl_rdata)
	);

endmodule
